/* src/booth_radix2_multiplier_defines.svh */
// Assertion macros shared by the checker of the Booth multiplier.
// Depends on nothing; every file that asserts includes this header.
`ifndef BOOTH_RADIX2_MULTIPLIER_DEFINES_SVH
`define BOOTH_RADIX2_MULTIPLIER_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define BRM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the block's own clock and reset names.
`define BRM_ASSERT(label, prop, msg) \
  `BRM_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* src/brm_pkg.sv */
// Package of the radix-2 Booth multiplier: widths, reset values and codes.
// Used by the controller, the datapath and the top level.
package brm_pkg;

  // Fixed field widths.
  localparam int unsigned OPERAND_W   = 32;
  localparam int unsigned PRODUCT_W   = 64;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned ACC_W       = OPERAND_W + 2;
  localparam int unsigned IN_TDATA_W  = 2 * OPERAND_W;
  localparam int unsigned OUT_TDATA_W = PRODUCT_W;

  // Default for the MAX_WIDTH parameter and reset value of operand_width.
  localparam int unsigned MAX_WIDTH_DEF = 32;
  localparam logic [CFG_W-1:0] OPERAND_WIDTH_RST = 6'd32;

  // Booth recoding of the pair {current bit, previous bit}.
  localparam logic [1:0] BOOTH_ADD = 2'b01;
  localparam logic [1:0] BOOTH_SUB = 2'b10;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } brm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } brm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_step;
  } brm_status_t;

endpackage

/* src/brm_ctrl.sv */
// Controller state machine of the radix-2 Booth multiplier.
// Depends on brm_pkg for the state enum and the command and status structs.
module brm_ctrl import brm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  brm_status_t status_i,
  output brm_cmd_t    cmd_o
);

  brm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.last_step) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands, handshake outputs and the output-valid flag.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.capture = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase

    // A captured result raises valid; a taken one drops it.
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/brm_datapath.sv */
// Datapath of the radix-2 Booth multiplier: width register, operand registers,
// shared add/subtract unit, step counter and output register. Depends on brm_pkg.
module brm_datapath import brm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [OPERAND_W-1:0]  multiplicand_i,
  input  logic [OPERAND_W-1:0]  multiplier_i,
  input  brm_cmd_t              cmd_i,
  output brm_status_t           status_o,
  output logic [PRODUCT_W-1:0]  product_o
);

  localparam int unsigned CNT_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SIGN_W = $clog2(OPERAND_W);
  localparam int unsigned PAIR_W = ACC_W + MAX_WIDTH;

  logic [CFG_W-1:0]            op_width_q;
  logic [CFG_W-1:0]            width_eff;
  logic [SIGN_W-1:0]           sign_idx;
  logic [MAX_WIDTH-1:0]        q_load;
  logic signed [ACC_W-1:0]     m_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [ACC_W-1:0]     sum;
  logic [MAX_WIDTH-1:0]        q_q;
  logic                        prev_q;
  logic [CNT_W-1:0]            cnt_q;
  logic signed [PAIR_W-1:0]    pair_val;
  logic [PRODUCT_W-1:0]        product_q;

  // Operand width register, reset to the full width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_width_q <= OPERAND_WIDTH_RST;
    end else if (cfg_we_i) begin
      op_width_q <= cfg_data_i;
    end
  end

  // Saturate the width and sign-extend the used multiplier bits to MAX_WIDTH.
  assign width_eff = (op_width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : op_width_q;
  assign sign_idx  = SIGN_W'(width_eff - CFG_W'(1));

  always_comb begin
    for (int i = 0; i < int'(MAX_WIDTH); i++) begin
      if (width_eff == '0) begin
        q_load[i] = 1'b0;
      end else if (CFG_W'(i) < width_eff) begin
        q_load[i] = multiplier_i[i];
      end else begin
        q_load[i] = multiplier_i[sign_idx];
      end
    end
  end

  // Booth recoding of the current and previous multiplier bits.
  always_comb begin
    case ({q_q[0], prev_q})
      BOOTH_ADD: sum = acc_q + m_q;
      BOOTH_SUB: sum = acc_q - m_q;
      default:   sum = acc_q;
    endcase
  end

  // Working registers: load, then one add/subtract and arithmetic shift per step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q    <= ACC_W'($signed(multiplicand_i));
      acc_q  <= '0;
      q_q    <= q_load;
      prev_q <= 1'b0;
    end else if (cmd_i.step) begin
      acc_q  <= {sum[ACC_W-1], sum[ACC_W-1:1]};
      q_q    <= {sum[0], q_q[MAX_WIDTH-1:1]};
      prev_q <= q_q[0];
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign status_o.last_step = cmd_i.step && (cnt_q == CNT_W'(MAX_WIDTH - 1));

  // Output register takes the low product bits of {acc, q}.
  assign pair_val = {acc_q, q_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      product_q <= PRODUCT_W'(pair_val);
    end
  end

  assign product_o = product_q;

endmodule

/* src/booth_radix2_multiplier.sv */
// Signed radix-2 Booth multiplier, 32 x 32 to 64 bits, with a width register.
// Top level: instantiates brm_ctrl and brm_datapath; depends on brm_pkg.
//
// An item is taken on the input stream, then the single shared add/subtract
// unit runs MAX_WIDTH (32 by default) Booth steps, one per cycle; then, once
// the output register is free or its product is being taken, the product
// moves into the output register, and only then is a new item accepted.
// The input side stays open while one finished product waits to be taken;
// if the next product is finished before that, the block holds it and keeps
// the input closed until the waiting output transaction happens.
// The step count does not depend on operand_width: the low operand_width bits
// of the multiplier are sign-extended to MAX_WIDTH bits before the first step,
// widths above MAX_WIDTH count as MAX_WIDTH, and a width of zero gives zero.
// The configuration write is always ready and must only happen while idle.
module booth_radix2_multiplier import brm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write: operand_width.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] multiplicand_in, [63:32] multiplier_in
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [63:0] product_out
);

  brm_cmd_t    cmd;
  brm_status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  brm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Booth datapath.
  brm_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .multiplicand_i (s_axis_tdata[OPERAND_W-1:0]),
    .multiplier_i   (s_axis_tdata[IN_TDATA_W-1:OPERAND_W]),
    .cmd_i          (cmd),
    .status_o       (status),
    .product_o      (m_axis_tdata)
  );

endmodule

/* src/brm_checker.sv */
// Port-level checker of the radix-2 Booth multiplier and its bind statement.
// Depends on booth_radix2_multiplier_defines.svh and brm_pkg.
`include "booth_radix2_multiplier_defines.svh"

module brm_checker import brm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled product stays valid and unchanged.
  `BRM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // The input side is still closed at the last Booth step after a transaction.
  `BRM_ASSERT(a_busy_steps, s_axis_tvalid && s_axis_tready |-> ##(MAX_WIDTH) !s_axis_tready, "input reopened early")

  // A new product only appears at the end of a multiplication.
  `BRM_ASSERT(a_out_after_run, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "product without a run")

endmodule

bind booth_radix2_multiplier brm_checker #(
  .MAX_WIDTH (MAX_WIDTH)
) u_brm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
